// ----- sv/lkv_pkg.sv -----
// Shared types and constants for the LRU key-value cache.
// No dependencies; used by lkv_ctrl, lkv_dp and lru_key_value_cache_unit.
package lkv_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int RANK_W      = IDX_W;
  localparam int OCC_W       = $clog2(MAX_ENTRIES + 1);

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(16);
  localparam logic [VALUE_W-1:0] MISS_VALUE  = '1;  // -1

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_DISPATCH,
    ST_INSERT
  } state_e;

  // Request kinds carried on the input tuser bit.
  typedef enum logic {
    REQ_LOOKUP = 1'b0,
    REQ_STORE  = 1'b1
  } req_type_e;

  // Controller to datapath.
  typedef struct packed {
    logic capture;   // latch incoming request
    logic match;     // register parallel key compare
    logic touch;     // make hit entry most recent
    logic write;     // overwrite hit entry data
    logic evict;     // drop least recent entry
    logic insert;    // place request in a free slot
    logic load_out;  // load result register
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic is_store;
    logic hit;
    logic full;
    logic out_free;
  } status_t;

endpackage

// ----- sv/lru_key_value_cache_unit.sv -----
// Top level of the LRU key-value cache: stream ports, configuration port.
// Depends on lkv_pkg, lkv_ctrl and lkv_dp.
//
// Fully associative key-value cache of lkv_pkg::MAX_ENTRIES entries with
// least-recently-used replacement. A lookup (tuser = 0) returns one
// transaction on the master side: tuser = found, tdata = stored value, or
// tdata = -1 with found = 0 on a miss; a hit makes the entry most recent.
// A store (tuser = 1) returns nothing; it overwrites an existing key and makes
// it most recent, or inserts the key as most recent, first evicting the least
// recent entry once occupancy reaches the capacity limit. The limit register
// (cfg_we_i/cfg_wdata_i, reset 16) reads 0 as 1 and saturates at the entry
// count; lowering it below the current occupancy does not drop entries, it
// only makes every new-key store evict one. Write it only while idle.
// Sequencing: one request at a time, taken by the controller in turn. Every
// request passes through accept, registered key compare and update before
// the next accept; a store of a new key into a full cache adds a separate
// insertion step after the eviction. A lookup also waits in its update step
// while the previous result is still held on the master side. The result
// register decouples the two sides, so a new request is taken while a result
// waits. No clearing pass: valid bits and ranks reset at once.
module lru_key_value_cache_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [lkv_pkg::LIMIT_W-1:0]   cfg_wdata_i,   // capacity_limit
  // request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [63:0]                   s_axis_tdata,  // [31:0] req_key, [63:32] req_value
  input  logic                          s_axis_tuser,  // [0] req_type
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [31:0]                   m_axis_tdata,  // [31:0] read_value
  output logic                          m_axis_tuser   // [0] found
);

  lkv_pkg::cmd_t    cmd;
  lkv_pkg::status_t status;

  lkv_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lkv_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_type_i  (s_axis_tuser),
    .req_key_i   (s_axis_tdata[31:0]),
    .req_value_i (s_axis_tdata[63:32]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_found_o (m_axis_tuser),
    .out_value_o (m_axis_tdata)
  );

endmodule

// ----- sv/lkv_ctrl.sv -----
// Sequencing state machine for the LRU key-value cache.
// Depends on lkv_pkg; drives lkv_dp through cmd_t and reads status_t.
module lkv_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  lkv_pkg::status_t status_i,
  output lkv_pkg::cmd_t    cmd_o
);

  lkv_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkv_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      lkv_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lkv_pkg::ST_MATCH;
        end
      end
      lkv_pkg::ST_MATCH: begin
        cmd_o.match = 1'b1;
        state_d     = lkv_pkg::ST_DISPATCH;
      end
      lkv_pkg::ST_DISPATCH: begin
        if (!status_i.is_store) begin
          // lookup waits here until the result register can take it
          if (status_i.out_free) begin
            cmd_o.load_out = 1'b1;
            cmd_o.touch    = status_i.hit;
            state_d        = lkv_pkg::ST_IDLE;
          end
        end else if (status_i.hit) begin
          cmd_o.touch = 1'b1;
          cmd_o.write = 1'b1;
          state_d     = lkv_pkg::ST_IDLE;
        end else if (status_i.full) begin
          cmd_o.evict = 1'b1;
          state_d     = lkv_pkg::ST_INSERT;
        end else begin
          cmd_o.insert = 1'b1;
          state_d      = lkv_pkg::ST_IDLE;
        end
      end
      lkv_pkg::ST_INSERT: begin
        cmd_o.insert = 1'b1;
        state_d      = lkv_pkg::ST_IDLE;
      end
      default: begin
        state_d = lkv_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- sv/lkv_dp.sv -----
// Datapath of the LRU key-value cache: entry store, recency ranks, result register.
// Depends on lkv_pkg; commanded by lkv_ctrl.
module lkv_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lkv_pkg::cmd_t                 cmd_i,
  output lkv_pkg::status_t              status_o,
  input  logic                          cfg_we_i,
  input  logic [lkv_pkg::LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                          req_type_i,
  input  logic [lkv_pkg::KEY_W-1:0]     req_key_i,
  input  logic [lkv_pkg::VALUE_W-1:0]   req_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_found_o,
  output logic [lkv_pkg::VALUE_W-1:0]   out_value_o
);

  localparam int N = lkv_pkg::MAX_ENTRIES;

  logic                          req_store_q;
  logic [lkv_pkg::KEY_W-1:0]     req_key_q;
  logic [lkv_pkg::VALUE_W-1:0]   req_value_q;
  logic [lkv_pkg::LIMIT_W-1:0]   limit_q;

  logic [N-1:0]                  valid_q, valid_d;
  logic [lkv_pkg::KEY_W-1:0]     key_q   [N];
  logic [lkv_pkg::VALUE_W-1:0]   data_q  [N];
  logic [lkv_pkg::RANK_W-1:0]    rank_q  [N];
  logic [lkv_pkg::RANK_W-1:0]    rank_d  [N];
  logic [lkv_pkg::OCC_W-1:0]     occ_q, occ_d;

  logic [N-1:0]                  match_vec, hit_vec_q;
  logic [lkv_pkg::IDX_W-1:0]     match_idx, hit_idx_q;
  logic                          hit_q;

  logic [N-1:0]                  victim_vec;
  logic [lkv_pkg::IDX_W-1:0]     free_idx;
  logic [lkv_pkg::RANK_W-1:0]    hit_rank, oldest_rank;
  logic [lkv_pkg::OCC_W-1:0]     eff_limit;

  logic                          out_valid_q, out_found_q;
  logic [lkv_pkg::VALUE_W-1:0]   out_value_q;

  // parallel compare, keys among valid entries are unique
  always_comb begin
    match_idx = '0;
    for (int i = 0; i < N; i++) begin
      match_vec[i] = valid_q[i] && (key_q[i] == req_key_q);
      if (match_vec[i]) match_idx = lkv_pkg::IDX_W'(i);
    end
  end

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!valid_q[i]) free_idx = lkv_pkg::IDX_W'(i);
    end
  end

  // valid ranks are always 0 .. occ-1, so the oldest holds occ-1
  assign oldest_rank = lkv_pkg::RANK_W'(occ_q - lkv_pkg::OCC_W'(1));
  always_comb begin
    for (int i = 0; i < N; i++) begin
      victim_vec[i] = valid_q[i] && (rank_q[i] == oldest_rank);
    end
  end

  assign hit_rank = rank_q[hit_idx_q];

  always_comb begin
    if (limit_q == '0) begin
      eff_limit = lkv_pkg::OCC_W'(1);
    end else if (int'(limit_q) > N) begin
      eff_limit = lkv_pkg::OCC_W'(N);
    end else begin
      eff_limit = lkv_pkg::OCC_W'(limit_q);
    end
  end

  always_comb begin
    valid_d = valid_q;
    occ_d   = occ_q;
    for (int i = 0; i < N; i++) begin
      rank_d[i] = rank_q[i];
      if (cmd_i.touch) begin
        if (valid_q[i] && (rank_q[i] < hit_rank)) begin
          rank_d[i] = rank_q[i] + lkv_pkg::RANK_W'(1);
        end
        if (lkv_pkg::IDX_W'(i) == hit_idx_q) rank_d[i] = '0;
      end
      if (cmd_i.evict && victim_vec[i]) begin
        valid_d[i] = 1'b0;
        rank_d[i]  = '0;
      end
      if (cmd_i.insert) begin
        if (valid_q[i]) rank_d[i] = rank_q[i] + lkv_pkg::RANK_W'(1);
        if (lkv_pkg::IDX_W'(i) == free_idx) begin
          valid_d[i] = 1'b1;
          rank_d[i]  = '0;
        end
      end
    end
    if (cmd_i.evict)  occ_d = occ_q - lkv_pkg::OCC_W'(1);
    if (cmd_i.insert) occ_d = occ_q + lkv_pkg::OCC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      occ_q       <= '0;
      limit_q     <= lkv_pkg::LIMIT_RESET;
      hit_q       <= 1'b0;
      hit_vec_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < N; i++) rank_q[i] <= '0;
    end else begin
      valid_q <= valid_d;
      occ_q   <= occ_d;
      for (int i = 0; i < N; i++) rank_q[i] <= rank_d[i];
      if (cfg_we_i) limit_q <= cfg_wdata_i;
      if (cmd_i.match) begin
        hit_q     <= |match_vec;
        hit_vec_q <= match_vec;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_store_q <= req_type_i;
      req_key_q   <= req_key_i;
      req_value_q <= req_value_i;
    end
    if (cmd_i.match) hit_idx_q <= match_idx;
    if (cmd_i.write) data_q[hit_idx_q] <= req_value_q;
    if (cmd_i.insert) begin
      key_q[free_idx]  <= req_key_q;
      data_q[free_idx] <= req_value_q;
    end
    if (cmd_i.load_out) begin
      out_found_q <= hit_q;
      out_value_q <= hit_q ? data_q[hit_idx_q] : lkv_pkg::MISS_VALUE;
    end
  end

  assign status_o.is_store = (req_store_q == lkv_pkg::REQ_STORE);
  assign status_o.hit      = hit_q;
  assign status_o.full     = (occ_q >= eff_limit);
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_found_o = out_found_q;
  assign out_value_o = out_value_q;

  a_occ_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy out of step with valid bits");

  a_hit_unique: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(hit_vec_q))
    else $error("key present in more than one entry");

  a_evict_one: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.evict |-> $onehot(victim_vec))
    else $error("eviction without a single oldest entry");

  a_load_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before taken");

endmodule
